// File: hw/rtl/kalman_1d_position_velocity_tracker_macros.svh
// Assertion macros used by the file that checks the tracker.
`ifndef KALMAN_1D_POSITION_VELOCITY_TRACKER_MACROS_SVH
`define KALMAN_1D_POSITION_VELOCITY_TRACKER_MACROS_SVH

// Checked at every rising edge outside reset.
`define KF1D_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define KF1D_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// File: hw/rtl/kf1d_pkg.sv
`timescale 1ns / 1ps

package kf1d_pkg;

  localparam int unsigned STATE_WIDTH = 32;
  localparam int unsigned CD_WIDTH    = 18;
  localparam int unsigned CFG_IDX_W   = 8;

  localparam logic [CFG_IDX_W-1:0] REG_POS_NOISE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_NOISE = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 8'd3;

  localparam logic [31:0] POS_NOISE_RST  = 32'd655360;
  localparam logic [31:0] VEL_NOISE_RST  = 32'd655360;
  localparam logic [31:0] MEAS_NOISE_RST = 32'd196608;
  localparam logic [15:0] TIMEOUT_RST    = 16'd3000;

  localparam logic signed [CD_WIDTH-1:0] CD_MIN = 18'sh20000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_MEAS,
    ST_DIV0_GO,
    ST_DIV0_WAIT,
    ST_DIV1_GO,
    ST_DIV1_WAIT,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    MOP_K0Y,
    MOP_K1Y,
    MOP_K0P00,
    MOP_K0P01,
    MOP_K1P01,
    MOP_V_DT,
    MOP_DT_P01,
    MOP_DT_P11,
    MOP_DT_T01
  } mop_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic new_track;
    logic meas_prep;
    logic zero_gain;
    logic div_start;
    logic div_wb;
    logic div_sel;
    logic mul_start;
    logic mul_wb;
    mop_t mul_op;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic cd_pos;
    logic tick_alive;
    logic s_pos;
    logic div_done;
    logic mul_done;
  } status_t;

  // Magnitude m with sign neg, saturated to a signed field of w bits.
  function automatic logic signed [63:0] sat_mag(input logic [127:0] m, input logic neg,
                                                 input int unsigned w);
    logic [127:0] lim;
    logic [127:0] v;
    logic [63:0]  r;
    lim = ((128'd1 << (w - 1)) - 128'd1) + {127'd0, neg};
    v   = (m > lim) ? lim : m;
    r   = v[63:0];
    return neg ? signed'(64'd0 - r) : signed'(r);
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input int unsigned w);
    logic signed [64:0] s;
    logic signed [64:0] mx;
    logic signed [64:0] mn;
    s  = 65'(a) + 65'(b);
    mx = (65'sd1 <<< (w - 1)) - 65'sd1;
    mn = -mx - 65'sd1;
    if (s > mx) s = mx;
    else if (s < mn) s = mn;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input int unsigned w);
    logic signed [64:0] s;
    logic signed [64:0] mx;
    logic signed [64:0] mn;
    s  = 65'(a) - 65'(b);
    mx = (65'sd1 <<< (w - 1)) - 65'sd1;
    mn = -mx - 65'sd1;
    if (s > mx) s = mx;
    else if (s < mn) s = mn;
    return s[63:0];
  endfunction

endpackage

// File: hw/rtl/kf1d_mul.sv
`timescale 1ns / 1ps

module kf1d_mul #(
  parameter int unsigned CF = 24,
  parameter int unsigned CW = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic               frac,
  input  logic               cov,
  output logic               done,
  output logic signed [63:0] res
);

  logic [63:0]  ma;
  logic [63:0]  mb;
  logic         neg;
  logic         sh_frac;
  logic         w_cov;
  logic [127:0] acc;
  logic [1:0]   idx;
  logic         busy;
  logic         fin;
  logic [31:0]  pa;
  logic [31:0]  pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [127:0] shifted;

  assign pa = idx[1] ? ma[63:32] : ma[31:0];
  assign pb = idx[0] ? mb[63:32] : mb[31:0];
  assign pp = pa * pb;

  always_comb begin
    case (idx)
      2'b00:   pp_sh = {64'd0, pp};
      2'b11:   pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  assign shifted = sh_frac ? (acc >> CF) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        idx  <= 2'd0;
        acc  <= 128'd0;
      end else if (busy) begin
        acc <= acc + pp_sh;
        idx <= idx + 2'd1;
        if (idx == 2'd3) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        res  <= kf1d_pkg::sat_mag(shifted, neg, w_cov ? CW : kf1d_pkg::STATE_WIDTH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma      <= a[63] ? (64'd0 - a) : a;
      mb      <= b[63] ? (64'd0 - b) : b;
      neg     <= a[63] ^ b[63];
      sh_frac <= frac;
      w_cov   <= cov;
    end
  end

endmodule

// File: hw/rtl/kf1d_div.sv
`timescale 1ns / 1ps

module kf1d_div #(
  parameter int unsigned CF = 24,
  parameter int unsigned CW = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [63:0]        den,
  output logic               done,
  output logic signed [63:0] res
);

  logic [127:0] n;
  logic [127:0] q;
  logic [63:0]  d;
  logic [63:0]  r;
  logic         neg;
  logic [6:0]   cnt;
  logic         busy;
  logic         fin;
  logic [64:0]  r2;
  logic         qbit;
  logic [64:0]  r_sub;
  logic [63:0]  num_mag;

  assign num_mag = num[63] ? (64'd0 - num) : num;
  assign r2      = {r, n[127]};
  assign qbit    = (r2 >= {1'b0, d});
  assign r_sub   = r2 - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'd127) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n   <= {64'd0, num_mag} << CF;
      d   <= den;
      r   <= 64'd0;
      q   <= 128'd0;
      neg <= num[63];
    end else if (busy) begin
      n <= {n[126:0], 1'b0};
      q <= {q[126:0], qbit};
      r <= qbit ? r_sub[63:0] : r2[63:0];
    end else if (fin) begin
      res <= kf1d_pkg::sat_mag(q, neg, CW);
    end
  end

endmodule

// File: hw/rtl/kf1d_datapath.sv
`timescale 1ns / 1ps

module kf1d_datapath #(
  parameter int unsigned SFB = 16,
  parameter int unsigned CW  = 48
) (
  input  logic                             clk,
  input  logic                             rst,
  input  kf1d_pkg::cmd_t                   cmd,
  output kf1d_pkg::status_t                stat,
  input  logic                             cfg_we,
  input  logic [kf1d_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [31:0]                      cfg_wdata,
  input  logic [47:0]                      in_data,
  output logic [63:0]                      out_data,
  output logic                             out_flag
);

  localparam int unsigned CF   = CW / 2;
  localparam int          DSH  = int'(CF) - int'(SFB);
  localparam int unsigned TC_L = (DSH >= 0) ? DSH : 0;
  localparam int unsigned TC_R = (DSH < 0) ? -DSH : 0;
  localparam int unsigned SW   = kf1d_pkg::STATE_WIDTH;
  localparam int unsigned CDW  = kf1d_pkg::CD_WIDTH;

  logic [31:0] pos_noise;
  logic [31:0] vel_noise;
  logic [31:0] meas_noise;
  logic [15:0] timeout;

  logic signed [SW-1:0]  z;
  logic [15:0]           dt;
  logic signed [SW-1:0]  prior0, prior1, post0, post1, rep0, rep1, y, tx0;
  logic signed [CW-1:0]  pc0, pc1, pc2, qc0, qc1, qc2, s, k0, k1, tt00, tt01;
  logic signed [CDW-1:0] cd;
  logic signed [CDW:0]   cd_diff;
  logic signed [CDW-1:0] cd_tick;

  logic signed [63:0] mul_a, mul_b, mul_res, div_res;
  logic               mul_frac, mul_cov, mul_done, div_done;
  logic signed [63:0] rq, qp, qv, n00, y_full, s_full;

  function automatic logic signed [63:0] to_cov(input logic [31:0] u);
    logic [127:0] m;
    m = ({96'd0, u} << TC_L) >> TC_R;
    return kf1d_pkg::sat_mag(m, 1'b0, CW);
  endfunction

  assign rq = to_cov(meas_noise);
  assign qp = to_cov(pos_noise);
  assign qv = to_cov(vel_noise);

  assign cd_diff = {cd[CDW-1], cd} - {3'd0, dt};
  assign cd_tick = (cd_diff < $signed({kf1d_pkg::CD_MIN[CDW-1], kf1d_pkg::CD_MIN}))
                 ? kf1d_pkg::CD_MIN : cd_diff[CDW-1:0];

  assign y_full = kf1d_pkg::sub_sat(64'(z), 64'(prior0), SW);
  assign s_full = kf1d_pkg::add_sat(64'(pc0), rq, CW);

  assign stat.cd_pos     = (cd > 0);
  assign stat.tick_alive = (cd_tick > 0);
  assign stat.s_pos      = (s > 0);
  assign stat.div_done   = div_done;
  assign stat.mul_done   = mul_done;

  always_comb begin
    mul_a    = 64'sd0;
    mul_b    = 64'sd0;
    mul_frac = 1'b0;
    mul_cov  = 1'b0;
    case (cmd.mul_op)
      kf1d_pkg::MOP_K0Y: begin
        mul_a = 64'(k0); mul_b = 64'(y); mul_frac = 1'b1;
      end
      kf1d_pkg::MOP_K1Y: begin
        mul_a = 64'(k1); mul_b = 64'(y); mul_frac = 1'b1;
      end
      kf1d_pkg::MOP_K0P00: begin
        mul_a = 64'(k0); mul_b = 64'(pc0); mul_frac = 1'b1; mul_cov = 1'b1;
      end
      kf1d_pkg::MOP_K0P01: begin
        mul_a = 64'(k0); mul_b = 64'(pc1); mul_frac = 1'b1; mul_cov = 1'b1;
      end
      kf1d_pkg::MOP_K1P01: begin
        mul_a = 64'(k1); mul_b = 64'(pc1); mul_frac = 1'b1; mul_cov = 1'b1;
      end
      kf1d_pkg::MOP_V_DT: begin
        mul_a = 64'(post1); mul_b = {48'd0, dt};
      end
      kf1d_pkg::MOP_DT_P01: begin
        mul_a = {48'd0, dt}; mul_b = 64'(qc1); mul_cov = 1'b1;
      end
      kf1d_pkg::MOP_DT_P11: begin
        mul_a = {48'd0, dt}; mul_b = 64'(qc2); mul_cov = 1'b1;
      end
      kf1d_pkg::MOP_DT_T01: begin
        mul_a = {48'd0, dt}; mul_b = 64'(tt01); mul_cov = 1'b1;
      end
      default: begin
        mul_a = 64'sd0;
      end
    endcase
  end

  assign n00 = kf1d_pkg::add_sat(kf1d_pkg::add_sat(64'(tt00), mul_res, CW), qp, CW);

  kf1d_mul #(.CF(CF), .CW(CW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .frac  (mul_frac),
    .cov   (mul_cov),
    .done  (mul_done),
    .res   (mul_res)
  );

  kf1d_div #(.CF(CF), .CW(CW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (cmd.div_sel ? 64'(pc1) : 64'(pc0)),
    .den   (64'(s)),
    .done  (div_done),
    .res   (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_noise  <= kf1d_pkg::POS_NOISE_RST;
      vel_noise  <= kf1d_pkg::VEL_NOISE_RST;
      meas_noise <= kf1d_pkg::MEAS_NOISE_RST;
      timeout    <= kf1d_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        kf1d_pkg::REG_POS_NOISE:  pos_noise  <= cfg_wdata;
        kf1d_pkg::REG_VEL_NOISE:  vel_noise  <= cfg_wdata;
        kf1d_pkg::REG_MEAS_NOISE: meas_noise <= cfg_wdata;
        kf1d_pkg::REG_TIMEOUT:    timeout    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cd     <= '0;
      prior0 <= '0;
      prior1 <= '0;
      post0  <= '0;
      post1  <= '0;
      rep0   <= '0;
      rep1   <= '0;
      pc0    <= '0;
      pc1    <= '0;
      pc2    <= '0;
      qc0    <= '0;
      qc1    <= '0;
      qc2    <= '0;
    end else begin
      if (cmd.tick) cd <= cd_tick;
      if (cmd.new_track || cmd.meas_prep) cd <= CDW'(timeout);
      if (cmd.new_track) begin
        post0 <= z;
        post1 <= '0;
        rep0  <= z;
        rep1  <= '0;
        qc0   <= CW'(1) <<< CF;
        qc1   <= '0;
        qc2   <= CW'(1) <<< CF;
      end
      if (cmd.mul_wb) begin
        case (cmd.mul_op)
          kf1d_pkg::MOP_K0Y:
            post0 <= SW'(kf1d_pkg::add_sat(64'(prior0), mul_res, SW));
          kf1d_pkg::MOP_K1Y:
            post1 <= SW'(kf1d_pkg::add_sat(64'(prior1), mul_res, SW));
          kf1d_pkg::MOP_K0P00:
            qc0 <= CW'(kf1d_pkg::sub_sat(64'(pc0), mul_res, CW));
          kf1d_pkg::MOP_K0P01:
            qc1 <= CW'(kf1d_pkg::sub_sat(64'(pc1), mul_res, CW));
          kf1d_pkg::MOP_K1P01: begin
            qc2  <= CW'(kf1d_pkg::sub_sat(64'(pc2), mul_res, CW));
            rep0 <= post0;
            rep1 <= post1;
          end
          kf1d_pkg::MOP_DT_T01: begin
            prior0 <= tx0;
            post0  <= tx0;
            rep0   <= tx0;
            prior1 <= post1;
            rep1   <= post1;
            pc0    <= CW'(n00);
            qc0    <= CW'(n00);
            pc1    <= tt01;
            qc1    <= tt01;
            pc2    <= CW'(kf1d_pkg::add_sat(64'(qc2), qv, CW));
            qc2    <= CW'(kf1d_pkg::add_sat(64'(qc2), qv, CW));
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      z  <= in_data[31:0];
      dt <= in_data[47:32];
    end
    if (cmd.meas_prep) begin
      y <= SW'(y_full);
      s <= CW'(s_full);
    end
    if (cmd.zero_gain) begin
      k0 <= '0;
      k1 <= '0;
    end
    if (cmd.div_wb) begin
      if (cmd.div_sel) k1 <= CW'(div_res);
      else k0 <= CW'(div_res);
    end
    if (cmd.mul_wb) begin
      case (cmd.mul_op)
        kf1d_pkg::MOP_V_DT:   tx0  <= SW'(kf1d_pkg::add_sat(64'(post0), mul_res, SW));
        kf1d_pkg::MOP_DT_P01: tt00 <= CW'(kf1d_pkg::add_sat(64'(qc0), mul_res, CW));
        kf1d_pkg::MOP_DT_P11: tt01 <= CW'(kf1d_pkg::add_sat(64'(qc1), mul_res, CW));
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_data <= {rep1, rep0};
      out_flag <= (cd > 0);
    end
  end

endmodule

// File: hw/rtl/kf1d_ctrl.sv
`timescale 1ns / 1ps

module kf1d_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_action,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  kf1d_pkg::status_t stat,
  output kf1d_pkg::cmd_t    cmd
);

  kf1d_pkg::state_t state, state_next;
  kf1d_pkg::mop_t   op, op_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kf1d_pkg::ST_IDLE;
      op        <= kf1d_pkg::MOP_K0Y;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.mul_op = op;
    in_ready   = 1'b0;
    case (state)
      kf1d_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = in_action ? kf1d_pkg::ST_TICK : kf1d_pkg::ST_MEAS;
        end
      end
      kf1d_pkg::ST_TICK: begin
        cmd.tick = 1'b1;
        if (stat.tick_alive) begin
          op_next    = kf1d_pkg::MOP_V_DT;
          state_next = kf1d_pkg::ST_MUL_GO;
        end else begin
          state_next = kf1d_pkg::ST_OUT;
        end
      end
      kf1d_pkg::ST_MEAS: begin
        if (stat.cd_pos) begin
          cmd.meas_prep = 1'b1;
          state_next    = kf1d_pkg::ST_DIV0_GO;
        end else begin
          cmd.new_track = 1'b1;
          state_next    = kf1d_pkg::ST_OUT;
        end
      end
      kf1d_pkg::ST_DIV0_GO: begin
        if (stat.s_pos) begin
          cmd.div_start = 1'b1;
          state_next    = kf1d_pkg::ST_DIV0_WAIT;
        end else begin
          cmd.zero_gain = 1'b1;
          op_next       = kf1d_pkg::MOP_K0Y;
          state_next    = kf1d_pkg::ST_MUL_GO;
        end
      end
      kf1d_pkg::ST_DIV0_WAIT: begin
        if (stat.div_done) begin
          cmd.div_wb = 1'b1;
          state_next = kf1d_pkg::ST_DIV1_GO;
        end
      end
      kf1d_pkg::ST_DIV1_GO: begin
        cmd.div_sel   = 1'b1;
        cmd.div_start = 1'b1;
        state_next    = kf1d_pkg::ST_DIV1_WAIT;
      end
      kf1d_pkg::ST_DIV1_WAIT: begin
        cmd.div_sel = 1'b1;
        if (stat.div_done) begin
          cmd.div_wb = 1'b1;
          op_next    = kf1d_pkg::MOP_K0Y;
          state_next = kf1d_pkg::ST_MUL_GO;
        end
      end
      kf1d_pkg::ST_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_next    = kf1d_pkg::ST_MUL_WAIT;
      end
      kf1d_pkg::ST_MUL_WAIT: begin
        if (stat.mul_done) begin
          cmd.mul_wb = 1'b1;
          if (op == kf1d_pkg::MOP_K1P01 || op == kf1d_pkg::MOP_DT_T01) begin
            state_next = kf1d_pkg::ST_OUT;
          end else begin
            op_next    = kf1d_pkg::mop_t'(op + 4'd1);
            state_next = kf1d_pkg::ST_MUL_GO;
          end
        end
      end
      kf1d_pkg::ST_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = kf1d_pkg::ST_IDLE;
        end
      end
      default: state_next = kf1d_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule

// File: hw/rtl/kalman_1d_position_velocity_tracker.sv
`timescale 1ns / 1ps
`include "kalman_1d_position_velocity_tracker_macros.svh"

// One-axis constant-velocity Kalman tracker. Items are handled one at a time
// by a state machine driving a datapath with one shared 32x32 multiplier (four
// partial products accumulated in turn per product) and a radix-2 divider. A
// measurement that starts a new track, or a tick once the track has expired,
// goes straight to the output state; a predicting tick runs four products; a
// correct step runs two gain divisions and five products, or only the five
// products when the innovation variance is not positive and no division runs.
// A result that is not yet read holds the next item in the output state. The
// next item is taken while the previous result still waits in the output
// register.

module kalman_1d_position_velocity_tracker #(
  parameter int unsigned STATE_FRAC_BITS = 16,
  parameter int unsigned COV_WIDTH       = 48
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // meas_position [31:0], elapsed_ms [47:32]
  input  logic        s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // est_position [31:0], est_velocity [63:32]
  output logic        m_tuser,   // has_position
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  kf1d_pkg::cmd_t    cmd;
  kf1d_pkg::status_t stat;

  assign cfg_ready = 1'b1;

  kf1d_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_action (s_tuser),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kf1d_datapath #(.SFB(STATE_FRAC_BITS), .CW(COV_WIDTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .in_data   (s_tdata),
    .out_data  (m_tdata),
    .out_flag  (m_tuser)
  );

  `KF1D_ASSERT(a_one_item, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "second item taken while busy")
  `KF1D_ASSERT(a_mul_latency, clk, rst, cmd.mul_start |=> !stat.mul_done, "product ready too early")
  `KF1D_ASSERT_ALWAYS(a_one_cmd, clk, $onehot0({cmd.mul_start, cmd.div_start, cmd.load, cmd.out_load}), "conflicting commands")

endmodule
